>>> rtl/blue_aqm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package blue_aqm_pkg;

    localparam int TimeBits  = 32;
    localparam int ProbBits  = 17;
    localparam int ByteBits  = 24;
    localparam int PktBits   = 16;
    localparam int CfgIdxBits = 3;
    localparam int CfgDataBits = 32;

    localparam logic [ProbBits-1:0] ProbOne  = 17'h10000;
    localparam logic [PktBits-1:0]  PktMax   = 16'hFFFF;

    localparam logic [CfgIdxBits-1:0] CfgByteMode  = 3'd0;
    localparam logic [CfgIdxBits-1:0] CfgQueueLim  = 3'd1;
    localparam logic [CfgIdxBits-1:0] CfgIncStep   = 3'd2;
    localparam logic [CfgIdxBits-1:0] CfgDecStep   = 3'd3;
    localparam logic [CfgIdxBits-1:0] CfgFreeze    = 3'd4;

    localparam logic [2:0] VerdictAccept  = 3'd0;
    localparam logic [2:0] VerdictForced  = 3'd1;
    localparam logic [2:0] VerdictEarly   = 3'd2;
    localparam logic [2:0] VerdictDeq     = 3'd3;
    localparam logic [2:0] VerdictDeqEmpty = 3'd4;

    typedef struct packed {
        logic        action;
        logic [31:0] now_ticks;
        logic [15:0] packet_size;
        logic [15:0] random_fraction;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  verdict;
        logic [16:0] mark_probability;
        logic [15:0] queued_packets;
        logic [23:0] queued_bytes;
        logic [31:0] forced_drop_count;
        logic [31:0] early_drop_count;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_DECAY,
        ST_DECIDE,
        ST_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture input item
        logic div_start; // begin idle division
        logic div_step;  // one quotient bit
        logic decay;     // apply quotient * decrement
        logic decide;    // main update
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_enq_idle;
        logic div_done;
    } status_t;

endpackage
`default_nettype wire

>>> rtl/blue_aqm_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module blue_aqm_datapath (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [2:0]               cfg_index,
    input  wire logic [31:0]              cfg_data,
    input  wire blue_aqm_pkg::in_item_t   in_item,
    input  wire blue_aqm_pkg::cmd_t       cmd,
    output blue_aqm_pkg::status_t         status,
    output blue_aqm_pkg::out_item_t       result
);

    // configuration registers
    logic        byte_mode_reg;
    logic [23:0] queue_limit_reg;
    logic [16:0] inc_step_reg;
    logic [16:0] dec_step_reg;
    logic [31:0] freeze_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_mode_reg   <= 1'b0;
            queue_limit_reg <= 24'd25;
            inc_step_reg    <= 17'd164;
            dec_step_reg    <= 17'd16;
            freeze_reg      <= 32'd100000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                blue_aqm_pkg::CfgByteMode: byte_mode_reg   <= cfg_data[0];
                blue_aqm_pkg::CfgQueueLim: queue_limit_reg <= cfg_data[23:0];
                blue_aqm_pkg::CfgIncStep:  inc_step_reg    <= cfg_data[16:0];
                blue_aqm_pkg::CfgDecStep:  dec_step_reg    <= cfg_data[16:0];
                blue_aqm_pkg::CfgFreeze:   freeze_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    // state
    logic [16:0] pmark_reg;
    logic [15:0] pkt_reg;
    logic [23:0] bytes_reg;
    logic [31:0] last_upd_reg;
    logic [31:0] idle_start_reg;
    logic        idle_flag_reg;
    logic [31:0] forced_reg;
    logic [31:0] early_reg;
    blue_aqm_pkg::in_item_t item_reg;
    logic [2:0]  verdict_reg;

    // restoring divider: quotient/remainder, 32 steps
    logic [31:0] quo_reg;
    logic [32:0] rem_reg;
    logic [31:0] dvd_reg;
    logic [5:0]  cnt_reg;

    logic [31:0] divisor;
    logic [32:0] rem_shift;
    logic [32:0] rem_sub;
    assign divisor   = (freeze_reg == 32'd0) ? 32'd1 : freeze_reg;
    assign rem_shift = {rem_reg[31:0], dvd_reg[31]};
    assign rem_sub   = rem_shift - {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 6'd0;
        end
        else if (cmd.div_start)
        begin
            cnt_reg <= 6'd0;
        end
        else if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg + 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            dvd_reg <= item_reg.now_ticks - idle_start_reg;
            rem_reg <= 33'd0;
            quo_reg <= 32'd0;
        end
        else if (cmd.div_step)
        begin
            dvd_reg <= {dvd_reg[30:0], 1'b0};
            if (!rem_sub[32])
            begin
                rem_reg <= rem_sub;
                quo_reg <= {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift;
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
    end

    assign status.div_done    = (cnt_reg == 6'd32);
    assign status.is_enq_idle = !item_reg.action && idle_flag_reg;

    // decay amount: saturate quotient to 17 bits (pmark <= 2^16 anyway)
    logic [16:0] quo_sat;
    logic [33:0] decay_amt;
    assign quo_sat   = (quo_reg[31:17] != 15'd0) ? 17'h1FFFF : quo_reg[16:0];
    assign decay_amt = quo_sat * dec_step_reg;

    // decision logic
    logic [31:0] since_upd;
    logic        gate_ok;
    logic [24:0] bytes_sum;
    logic        full;
    logic        early;
    logic [17:0] pm_inc;
    assign since_upd = item_reg.now_ticks - last_upd_reg;
    assign gate_ok   = since_upd > freeze_reg;
    assign bytes_sum = {1'b0, bytes_reg} + {9'd0, item_reg.packet_size};
    assign pm_inc    = {1'b0, pmark_reg} + {1'b0, inc_step_reg};
    always_comb
    begin
        full = byte_mode_reg ? (bytes_sum > {1'b0, queue_limit_reg})
                             : ({8'd0, pkt_reg} >= queue_limit_reg);
        if (pkt_reg == blue_aqm_pkg::PktMax || bytes_sum[24])
        begin
            full = 1'b1;
        end
        early = {1'b0, item_reg.random_fraction} < pmark_reg;
    end

    logic [15:0] pkt_dec;
    assign pkt_dec = pkt_reg - 16'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pmark_reg      <= '0;
            pkt_reg        <= '0;
            bytes_reg      <= '0;
            last_upd_reg   <= '0;
            idle_start_reg <= '0;
            idle_flag_reg  <= 1'b1;
            forced_reg     <= '0;
            early_reg      <= '0;
            verdict_reg    <= blue_aqm_pkg::VerdictAccept;
        end
        else if (cmd.decay)
        begin
            if (quo_reg != 32'd0)
            begin
                pmark_reg    <= (decay_amt >= {17'd0, pmark_reg}) ? 17'd0
                                : pmark_reg - decay_amt[16:0];
                last_upd_reg <= item_reg.now_ticks;
            end
            idle_flag_reg <= 1'b0;
        end
        else if (cmd.decide)
        begin
            if (!item_reg.action)
            begin
                idle_flag_reg <= 1'b0;
                if (full || early)
                begin
                    if (gate_ok)
                    begin
                        pmark_reg    <= (pm_inc > {1'b0, blue_aqm_pkg::ProbOne})
                                        ? blue_aqm_pkg::ProbOne : pm_inc[16:0];
                        last_upd_reg <= item_reg.now_ticks;
                    end
                    if (full)
                    begin
                        forced_reg  <= forced_reg + 32'd1;
                        verdict_reg <= blue_aqm_pkg::VerdictForced;
                    end
                    else
                    begin
                        early_reg   <= early_reg + 32'd1;
                        verdict_reg <= blue_aqm_pkg::VerdictEarly;
                    end
                end
                else
                begin
                    pkt_reg     <= pkt_reg + 16'd1;
                    bytes_reg   <= bytes_sum[23:0];
                    verdict_reg <= blue_aqm_pkg::VerdictAccept;
                end
            end
            else if (pkt_reg == 16'd0)
            begin
                verdict_reg <= blue_aqm_pkg::VerdictDeqEmpty;
            end
            else
            begin
                pkt_reg     <= pkt_dec;
                verdict_reg <= blue_aqm_pkg::VerdictDeq;
                if (pkt_dec == 16'd0)
                begin
                    bytes_reg <= '0;
                    if (!idle_flag_reg)
                    begin
                        idle_flag_reg  <= 1'b1;
                        idle_start_reg <= item_reg.now_ticks;
                        if (gate_ok)
                        begin
                            pmark_reg <= ({1'b0, dec_step_reg} >= {1'b0, pmark_reg})
                                         ? 17'd0 : pmark_reg - dec_step_reg;
                            last_upd_reg <= item_reg.now_ticks;
                        end
                    end
                end
                else
                begin
                    bytes_reg <= ({8'd0, item_reg.packet_size} >= bytes_reg) ? 24'd0
                                 : bytes_reg - {8'd0, item_reg.packet_size};
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_item;
        end
    end

    assign result.verdict           = verdict_reg;
    assign result.mark_probability  = pmark_reg;
    assign result.queued_packets    = pkt_reg;
    assign result.queued_bytes      = bytes_reg;
    assign result.forced_drop_count = forced_reg;
    assign result.early_drop_count  = early_reg;

endmodule
`default_nettype wire

>>> rtl/blue_aqm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module blue_aqm_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    input  wire blue_aqm_pkg::status_t status,
    output blue_aqm_pkg::cmd_t         cmd
);

    blue_aqm_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= blue_aqm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            blue_aqm_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = blue_aqm_pkg::ST_DIV;
                end
            end
            blue_aqm_pkg::ST_DIV:
            begin
                // idle enqueue runs the divider, others go straight on
                if (status.is_enq_idle)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = blue_aqm_pkg::ST_DECAY;
                end
                else
                begin
                    cmd.decide = 1'b1;
                    state_next = blue_aqm_pkg::ST_OUT;
                end
            end
            blue_aqm_pkg::ST_DECAY:
            begin
                if (status.div_done)
                begin
                    cmd.decay  = 1'b1;
                    state_next = blue_aqm_pkg::ST_DECIDE;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            blue_aqm_pkg::ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = blue_aqm_pkg::ST_OUT;
            end
            blue_aqm_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = blue_aqm_pkg::ST_IDLE;
                end
            end
            default: state_next = blue_aqm_pkg::ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/blue_aqm_drop_decider.sv
// Channel | Signals                          | Request
// in      | in_valid, in_ready, in_data      | enqueue/dequeue event
// out     | out_valid, out_ready, out_data   | verdict and counters
// cfg     | cfg_we, cfg_index, cfg_data      | register write
// One request at a time: each request passes accept, decide and result,
// the output handshake included; the first enqueue after idle also runs
// the 32-step serial divider and the decay before the decision.
// Reset is asynchronous; the state and configuration registers take their defaults.
// A stalled result holds in the output register; no new request is
// taken until it is delivered.
`timescale 1ns / 1ps
`default_nettype none
module blue_aqm_drop_decider (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire blue_aqm_pkg::in_item_t  in_data,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output blue_aqm_pkg::out_item_t      out_data,
    input  wire logic                    cfg_we,
    input  wire logic [2:0]              cfg_index,
    input  wire logic [31:0]             cfg_data
);

    blue_aqm_pkg::cmd_t    cmd;
    blue_aqm_pkg::status_t status;

    blue_aqm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    blue_aqm_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_item   (in_data),
        .cmd       (cmd),
        .status    (status),
        .result    (out_data)
    );

endmodule
`default_nettype wire

>>> rtl/blue_aqm_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module blue_aqm_checker (
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    in_valid,
    input wire logic                    in_ready,
    input wire logic                    out_valid,
    input wire logic                    out_ready,
    input wire blue_aqm_pkg::out_item_t out_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // never take a request while a result waits
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("ready while result pending");

    // pmark never above 1.0
    a_pmark: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.mark_probability <= blue_aqm_pkg::ProbOne)
        else $error("pmark out of range");

    // accepted request yields no result in the next cycle
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !out_valid)
        else $error("result too early");

endmodule

bind blue_aqm_drop_decider blue_aqm_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
`default_nettype wire
